// ===== rtl/dfe_pkg.sv =====
// ----------------------------------------------------------------------------
// DShot frame encoder package
// Shared widths, mode codes, register indexes, types and the frame builder.
// ----------------------------------------------------------------------------
package dfe_pkg;

    localparam int NUM_MOTORS = 4;

    localparam int MODE_W   = 3;
    localparam int MOTOR_W  = 2;
    localparam int FRAC_W   = 16;
    localparam int VALUE_W  = 11;
    localparam int SLOT_W   = 5;
    localparam int PULSE_W  = 16;
    localparam int FRAME_W  = 16;
    localparam int PERIOD_W = 16;
    localparam int PROD_W   = FRAC_W + VALUE_W;
    localparam int SUM_W    = VALUE_W + 2;
    localparam int CFG_W    = 32;
    localparam int PADDR_W  = 3;

    localparam int SLOT_COUNT = 18;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOT_COUNT - 1);

    localparam logic [MOTOR_W+2:0] MOTOR_LIMIT = (MOTOR_W + 3)'(NUM_MOTORS);

    localparam logic [VALUE_W-1:0] FULL_SCALE_SPAN = VALUE_W'(1999);
    localparam logic [SUM_W-1:0]   THROTTLE_BASE   = SUM_W'(48);
    localparam logic [SUM_W-1:0]   VALUE_MAX       = SUM_W'(2047);

    localparam logic [MODE_W-1:0] MODE_THROTTLE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_COUNT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RAW      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DISARM   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ARM      = 3'd4;

    localparam logic REG_BIT_PERIOD = 1'b0;
    localparam logic REG_MIN_OFFSET = 1'b1;

    localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd1120;
    localparam logic [VALUE_W-1:0]  MIN_OFFSET_RST = 11'd50;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        SRC_THROTTLE,
        SRC_COUNT,
        SRC_RAW,
        SRC_ZERO
    } t_val_src;

    typedef struct packed {
        logic [MOTOR_W-1:0] motor;
        logic [FRAME_W-1:0] frame;
    } t_frame_req;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [FRAME_W-1:0] build_frame(input logic [VALUE_W-1:0] value,
                                                       input logic telem);
        logic [VALUE_W:0] word12;
        logic [3:0]       csum;
        word12 = {value, telem};
        csum   = word12[3:0] ^ word12[7:4] ^ word12[11:8];
        return {word12, csum};
    endfunction

endpackage

// ===== rtl/dfe_if.sv =====
// ----------------------------------------------------------------------------
// DShot frame encoder channels
// Command request channel and slot request channel with valid/ready.
// ----------------------------------------------------------------------------
interface dfe_cmd_if;
    logic                           valid;
    logic                           ready;
    logic [dfe_pkg::MODE_W-1:0]     mode;
    logic [dfe_pkg::MOTOR_W-1:0]    motor;
    logic [dfe_pkg::FRAC_W-1:0]     throttle_fraction;
    logic [dfe_pkg::VALUE_W-1:0]    throttle_count;
    logic [dfe_pkg::VALUE_W-1:0]    command_value;

    modport source (output valid, mode, motor, throttle_fraction, throttle_count,
                    command_value, input ready);
    modport sink (input valid, mode, motor, throttle_fraction, throttle_count,
                  command_value, output ready);
endinterface

interface dfe_slot_if;
    logic                           valid;
    logic                           ready;
    logic [dfe_pkg::MOTOR_W-1:0]    motor_out;
    logic [dfe_pkg::SLOT_W-1:0]     slot;
    logic [dfe_pkg::PULSE_W-1:0]    pulse_width;
    logic [dfe_pkg::FRAME_W-1:0]    frame_word;
    logic                           last;

    modport source (output valid, motor_out, slot, pulse_width, frame_word, last,
                    input ready);
    modport sink (input valid, motor_out, slot, pulse_width, frame_word, last,
                  output ready);
endinterface

// ===== rtl/dfe_apb_regs.sv =====
// ----------------------------------------------------------------------------
// DShot frame encoder configuration registers
// APB-style register file holding the bit period and the throttle offset.
// ----------------------------------------------------------------------------
module dfe_apb_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dfe_pkg::PADDR_W-1:0]       paddr,
    input  logic [dfe_pkg::CFG_W-1:0]         pwdata,
    output logic [dfe_pkg::CFG_W-1:0]         prdata,
    output logic                              pready,
    output logic [dfe_pkg::PERIOD_W-1:0]      o_bit_period,
    output logic [dfe_pkg::VALUE_W-1:0]       o_min_offset
);

    logic [dfe_pkg::PERIOD_W-1:0] r_bit_period;
    logic [dfe_pkg::VALUE_W-1:0]  r_min_offset;
    logic                         wr_en;
    logic                         reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= dfe_pkg::BIT_PERIOD_RST;
            r_min_offset <= dfe_pkg::MIN_OFFSET_RST;
        end else if (wr_en) begin
            case (reg_sel)
                dfe_pkg::REG_BIT_PERIOD: r_bit_period <= pwdata[dfe_pkg::PERIOD_W-1:0];
                dfe_pkg::REG_MIN_OFFSET: r_min_offset <= pwdata[dfe_pkg::VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            dfe_pkg::REG_BIT_PERIOD: prdata = dfe_pkg::CFG_W'(r_bit_period);
            dfe_pkg::REG_MIN_OFFSET: prdata = dfe_pkg::CFG_W'(r_min_offset);
            default:                 prdata = '0;
        endcase
    end

    assign o_bit_period = r_bit_period;
    assign o_min_offset = r_min_offset;

endmodule

// ===== rtl/dfe_front.sv =====
// ----------------------------------------------------------------------------
// DShot frame encoder front end
// Accepts commands, tracks the armed state and builds frame words.
// ----------------------------------------------------------------------------
module dfe_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dfe_cmd_if.sink                       i_cmd,
    input  logic [dfe_pkg::VALUE_W-1:0]   i_min_offset,
    input  dfe_pkg::t_queue_status        i_q_status,
    output logic                          o_push,
    output dfe_pkg::t_frame_req           o_push_req
);

    logic                           r_armed;
    logic                           n_armed;
    logic                           r_s1_valid;
    logic [dfe_pkg::MOTOR_W-1:0]    r_s1_motor;
    dfe_pkg::t_val_src              r_s1_src;
    logic [dfe_pkg::PROD_W-1:0]     r_s1_prod;
    logic [dfe_pkg::VALUE_W-1:0]    r_s1_arg;

    logic                           accept;
    logic                           motor_ok;
    logic                           emit;
    dfe_pkg::t_val_src              src;
    logic [dfe_pkg::VALUE_W-1:0]    arg;
    logic [dfe_pkg::SUM_W-1:0]      sum;
    logic [dfe_pkg::VALUE_W-1:0]    value;

    assign accept       = i_cmd.valid & i_cmd.ready;
    assign motor_ok     = 5'(i_cmd.motor) < dfe_pkg::MOTOR_LIMIT;
    assign o_push       = r_s1_valid & ~i_q_status.full;
    assign i_cmd.ready  = ~r_s1_valid | ~i_q_status.full;

    always_comb begin
        emit    = 1'b0;
        src     = dfe_pkg::SRC_ZERO;
        arg     = '0;
        n_armed = r_armed;
        case (i_cmd.mode)
            dfe_pkg::MODE_THROTTLE: begin
                emit = r_armed & motor_ok;
                src  = dfe_pkg::SRC_THROTTLE;
            end
            dfe_pkg::MODE_COUNT: begin
                emit = motor_ok;
                src  = dfe_pkg::SRC_COUNT;
                arg  = i_cmd.throttle_count;
            end
            dfe_pkg::MODE_RAW: begin
                emit = motor_ok;
                src  = dfe_pkg::SRC_RAW;
                arg  = i_cmd.command_value;
            end
            dfe_pkg::MODE_DISARM: begin
                emit    = r_armed & motor_ok;
                n_armed = 1'b0;
            end
            dfe_pkg::MODE_ARM: begin
                n_armed = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= 1'b0;
            r_s1_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_armed <= n_armed;
            end
            if (accept && emit) begin
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_s1_motor <= i_cmd.motor;
            r_s1_src   <= src;
            r_s1_arg   <= arg;
            r_s1_prod  <= dfe_pkg::PROD_W'(i_cmd.throttle_fraction)
                        * dfe_pkg::PROD_W'(dfe_pkg::FULL_SCALE_SPAN);
        end
    end

    always_comb begin
        case (r_s1_src)
            dfe_pkg::SRC_THROTTLE:
                sum = dfe_pkg::SUM_W'(r_s1_prod[dfe_pkg::PROD_W-1:15]) + dfe_pkg::THROTTLE_BASE;
            dfe_pkg::SRC_COUNT:
                sum = dfe_pkg::SUM_W'(r_s1_arg) + dfe_pkg::THROTTLE_BASE
                    + dfe_pkg::SUM_W'(i_min_offset);
            default:
                sum = dfe_pkg::SUM_W'(r_s1_arg);
        endcase
        if (sum > dfe_pkg::VALUE_MAX) begin
            value = dfe_pkg::VALUE_MAX[dfe_pkg::VALUE_W-1:0];
        end else begin
            value = sum[dfe_pkg::VALUE_W-1:0];
        end
    end

    assign o_push_req.motor = r_s1_motor;
    assign o_push_req.frame = dfe_pkg::build_frame(value, r_s1_src == dfe_pkg::SRC_THROTTLE);

    a_disarm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_cmd.mode == dfe_pkg::MODE_DISARM |=> !r_armed)
        else $error("disarm command left the block armed");

endmodule

// ===== rtl/dfe_queue.sv =====
// ----------------------------------------------------------------------------
// DShot frame encoder frame queue
// Two-entry queue of built frames between the front end and the serializer.
// ----------------------------------------------------------------------------
module dfe_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  dfe_pkg::t_frame_req       i_push_req,
    input  logic                      i_pop,
    output dfe_pkg::t_frame_req       o_head,
    output dfe_pkg::t_queue_status    o_status
);

    dfe_pkg::t_frame_req             r_mem [dfe_pkg::QUEUE_DEPTH];
    logic [dfe_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [dfe_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [dfe_pkg::QCNT_W-1:0]      r_count;

    assign o_status.full  = r_count == dfe_pkg::QCNT_W'(dfe_pkg::QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_req;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push && !i_pop |-> !o_status.full)
        else $error("frame queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("frame queue read while empty");

endmodule

// ===== rtl/dfe_back.sv =====
// ----------------------------------------------------------------------------
// DShot frame encoder slot serializer
// Turns each queued frame into eighteen compare slots, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module dfe_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [dfe_pkg::PERIOD_W-1:0]  i_bit_period,
    input  dfe_pkg::t_frame_req           i_head,
    input  dfe_pkg::t_queue_status        i_q_status,
    output logic                          o_pop,
    dfe_slot_if.source                    o_slot
);

    logic                           r_valid;
    logic [dfe_pkg::SLOT_W-1:0]     r_slot;
    logic [dfe_pkg::MOTOR_W-1:0]    r_motor;
    logic [dfe_pkg::FRAME_W-1:0]    r_frame;
    logic [dfe_pkg::PULSE_W-1:0]    r_w_one;
    logic [dfe_pkg::PULSE_W-1:0]    r_w_zero;

    logic [dfe_pkg::PERIOD_W+1:0]   period_x3;
    logic                           advance;
    logic                           at_end;

    assign period_x3 = {2'b00, i_bit_period} + {1'b0, i_bit_period, 1'b0};
    assign at_end    = r_slot == dfe_pkg::SLOT_LAST;
    assign advance   = ~r_valid | o_slot.ready;
    assign o_pop     = advance & (~r_valid | at_end) & ~i_q_status.empty;

    always_ff @(posedge i_clk) begin
        r_w_one  <= period_x3[dfe_pkg::PERIOD_W+1:2];
        r_w_zero <= dfe_pkg::PULSE_W'(period_x3 >> 3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            if (!r_valid || at_end) begin
                r_valid <= ~i_q_status.empty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            if (!r_valid || at_end) begin
                r_slot  <= '0;
                r_motor <= i_head.motor;
                r_frame <= i_head.frame;
            end else begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    assign o_slot.valid       = r_valid;
    assign o_slot.motor_out   = r_motor;
    assign o_slot.slot        = r_slot;
    assign o_slot.frame_word  = r_frame;
    assign o_slot.last        = at_end;
    assign o_slot.pulse_width = r_slot[4] ? '0 : (r_frame[~r_slot[3:0]] ? r_w_one : r_w_zero);

    a_slot_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && o_slot.ready && !at_end |=>
            r_valid && r_slot == dfe_pkg::SLOT_W'($past(r_slot) + 1'b1))
        else $error("slot sequence skipped or stalled a slot");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_slot <= dfe_pkg::SLOT_LAST)
        else $error("slot index ran past the end of the frame");

endmodule

// ===== rtl/dshot_frame_encoder_unit.sv =====
// ----------------------------------------------------------------------------
// DShot frame encoder
// Each accepted command that produces a frame yields eighteen slot requests
// for one motor, one per cycle while the slot sink is ready; commands that
// produce no frame (arm, throttle or disarm while disarmed, unused modes) push
// nothing. The front end registers a command, builds its frame word and pushes
// it into a two-entry queue when not full; the first slot then passes that
// register, the queue entry and the serializer's slot register. Up to three
// frame-producing commands can be taken while a frame is still being sent,
// and a new frame follows the previous one's last slot with no gap.
// The user must write configuration through the APB-style port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module dshot_frame_encoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dfe_pkg::PADDR_W-1:0]   paddr,
    input  logic [dfe_pkg::CFG_W-1:0]     pwdata,
    output logic [dfe_pkg::CFG_W-1:0]     prdata,
    output logic                          pready,
    dfe_cmd_if.sink                       i_cmd,
    dfe_slot_if.source                    o_slot
);

    logic [dfe_pkg::PERIOD_W-1:0]   bit_period;
    logic [dfe_pkg::VALUE_W-1:0]    min_offset;
    logic                           push;
    logic                           pop;
    dfe_pkg::t_frame_req            push_req;
    dfe_pkg::t_frame_req            head;
    dfe_pkg::t_queue_status         q_status;

    dfe_apb_regs u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_bit_period (bit_period),
        .o_min_offset (min_offset)
    );

    dfe_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (i_cmd),
        .i_min_offset (min_offset),
        .i_q_status   (q_status),
        .o_push       (push),
        .o_push_req   (push_req)
    );

    dfe_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_req (push_req),
        .i_pop      (pop),
        .o_head     (head),
        .o_status   (q_status)
    );

    dfe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bit_period (bit_period),
        .i_head       (head),
        .i_q_status   (q_status),
        .o_pop        (pop),
        .o_slot       (o_slot)
    );

endmodule
